### rtl/vn2o_pkg.sv
// shared types, constants and the cosine blend table builder for the octave value noise block
// no dependencies
`default_nettype none

package vn2o_pkg;

  localparam int COORD_W   = 31;
  localparam int OCT_W     = 4;
  localparam int PERS_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 17;
  localparam int LAT_W     = 32;   // lattice value, units of 2^-30
  localparam int SM_W      = 36;   // smoothed value, units of 2^-34
  localparam int ACC_W     = 64;
  localparam int OUT_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 2'd1;

  localparam logic [OCT_W-1:0]  OCT_RESET  = 4'd4;
  localparam logic [PERS_W-1:0] PERS_RESET = 17'd32768;
  localparam logic [PERS_W-1:0] PERS_ONE   = 17'd65536;

  localparam logic [31:0] HASH_MUL_Y   = 32'd57;
  localparam logic [31:0] HASH_MUL_SQ  = 32'd15731;
  localparam logic [31:0] HASH_ADD_SQ  = 32'd789221;
  localparam logic [31:0] HASH_ADD_OUT = 32'd1376312589;

  localparam real PI_R = 3.14159265358979323846;

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [OCT_W-1:0]   octs;
    logic [PERS_W-1:0]  pers;
  } vn2o_item_t;

  // entry k of round(65536 * sin^2(pi*k / 2^(bits+1)))
  function automatic int vn2o_cos_entry(int k, int bits);
    real th;
    real s;
    th = PI_R * k;
    for (int b = 0; b <= bits; b++) th = th * 0.5;
    s  = $sin(th);
    return $rtoi($floor(65536.0 * s * s + 0.5));
  endfunction

endpackage

`default_nettype wire

### rtl/vn2o_front.sv
// front end: configuration registers and a two-entry request queue
// depends on vn2o_pkg
`default_nettype none

module vn2o_front #(
  parameter int MAX_OCTAVES = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [vn2o_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [vn2o_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [vn2o_pkg::COORD_W-1:0]   coord_x_i,
  input  wire logic [vn2o_pkg::COORD_W-1:0]   coord_y_i,
  output logic                                q_valid_o,
  output vn2o_pkg::vn2o_item_t                q_item_o,
  input  wire logic                           q_pop_i
);
  import vn2o_pkg::*;

  logic [OCT_W-1:0]  oct_count_q, oct_count_d;
  logic [PERS_W-1:0] pers_q, pers_d;
  vn2o_item_t        mem_q [2];
  vn2o_item_t        item;
  logic              wptr_q, rptr_q;
  logic [1:0]        count_q, count_d;
  logic              push;
  logic              pop;

  always_comb begin
    oct_count_d = oct_count_q;
    pers_d      = pers_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OCTAVE_COUNT: oct_count_d = cfg_data_i[OCT_W-1:0];
        REG_PERSISTENCE:  pers_d      = cfg_data_i[PERS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    item.cx   = coord_x_i;
    item.cy   = coord_y_i;
    item.octs = (oct_count_q > MAX_OCTAVES) ? OCT_W'(MAX_OCTAVES) : oct_count_q;
    item.pers = (pers_q > PERS_ONE) ? PERS_ONE : pers_q;
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (count_q != 2'd0);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = mem_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) count_d = count_q + 2'd1;
    else if (pop && !push) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_count_q <= OCT_RESET;
      pers_q      <= PERS_RESET;
      wptr_q      <= 1'b0;
      rptr_q      <= 1'b0;
      count_q     <= 2'd0;
    end else begin
      oct_count_q <= oct_count_d;
      pers_q      <= pers_d;
      count_q     <= count_d;
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= item;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop from empty queue");

endmodule

`default_nettype wire

### rtl/vn2o_hash.sv
// four-stage pipelined lattice hash, one corner per cycle
// depends on vn2o_pkg
`default_nettype none

module vn2o_hash (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic [31:0]                 x_i,
  input  wire logic [31:0]                 y_i,
  input  wire logic [3:0]                  tag_i,
  output logic                             valid_o,
  output logic [3:0]                       tag_o,
  output logic signed [vn2o_pkg::LAT_W-1:0] value_o
);
  import vn2o_pkg::*;

  logic [3:0]  v_q;
  logic [3:0]  tag1_q, tag2_q, tag3_q, tag4_q;
  logic [31:0] n1_q, n2_q, n3_q;
  logic [31:0] sq_q, t_q;
  logic signed [LAT_W-1:0] val_q;
  logic [31:0] n0, nx, h;

  assign n0 = x_i + y_i * HASH_MUL_Y;
  assign nx = (n0 << 13) ^ n0;
  assign h  = n3_q * t_q + HASH_ADD_OUT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 4'd0;
    end else begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q   <= nx;
    tag1_q <= tag_i;
    sq_q   <= n1_q * n1_q;
    n2_q   <= n1_q;
    tag2_q <= tag1_q;
    t_q    <= sq_q * HASH_MUL_SQ + HASH_ADD_SQ;
    n3_q   <= n2_q;
    tag3_q <= tag2_q;
    val_q  <= $signed(32'h4000_0000) - $signed({1'b0, h[30:0]});
    tag4_q <= tag3_q;
  end

  assign valid_o = v_q[3];
  assign tag_o   = tag4_q;
  assign value_o = val_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##4 valid_o) else $error("hash latency slip");

endmodule

`default_nettype wire

### rtl/vn2o_back.sv
// back end: octave sequencer, smoothing, cosine blend, accumulation and result register
// depends on vn2o_pkg and vn2o_hash
`default_nettype none

module vn2o_back #(
  parameter int FRACTION_BITS  = 16,
  parameter int COS_TABLE_BITS = 8,
  parameter int MAX_OCTAVES    = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_valid_i,
  input  wire vn2o_pkg::vn2o_item_t q_item_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [vn2o_pkg::OUT_W-1:0] noise_value_o
);
  import vn2o_pkg::*;

  localparam int SX_W  = COORD_W + MAX_OCTAVES + FRACTION_BITS + 1;
  localparam int TSIZE = 1 << COS_TABLE_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ISSUE  = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_SMOOTH = 3'd3;
  localparam logic [2:0] S_BLEND  = 3'd4;
  localparam logic [2:0] S_ACC    = 3'd5;
  localparam logic [2:0] S_FINAL  = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [3:0]         cnt_q;
  logic [OCT_W-1:0]   oct_q, octs_q;
  logic [COORD_W-1:0] cx_q, cy_q;
  logic [PERS_W-1:0]  pers_q, amp_q;
  logic [16:0]        fx_q, fy_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [LAT_W-1:0] grid_q [16];
  logic signed [SM_W-1:0]  sm_q [4];
  logic signed [SM_W-1:0]  bx0_q, bx1_q, o_q;
  logic signed [OUT_W-1:0] res_q;
  logic               out_valid_q;

  logic [16:0]             cos_lut [TSIZE];
  logic [SX_W-1:0]         sx, sy;
  logic [31:0]             cell_x, cell_y;
  logic [COS_TABLE_BITS-1:0] idx_x, idx_y;
  logic                    h_valid;
  logic [3:0]              h_tag;
  logic signed [LAT_W-1:0] h_value;
  logic signed [SM_W-1:0]  sm_sum [4];
  logic signed [SM_W-1:0]  la, lb, lres;
  logic [16:0]             lf;
  logic signed [SM_W:0]    ld;
  logic signed [SM_W+18:0] lp;
  logic signed [SM_W+19:0] ls;
  logic signed [SM_W+17:0] oa_prod;
  logic [2*PERS_W-1:0]     amp_prod;
  logic [2*PERS_W-1:0]     amp_rnd;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [ACC_W-25:0] res_wide;
  logic signed [OUT_W-1:0] res_sat;
  logic                    out_free;

  for (genvar k = 0; k < TSIZE; k++) begin : g_cos
    assign cos_lut[k] = 17'(vn2o_cos_entry(k, COS_TABLE_BITS));
  end

  assign sx     = SX_W'(cx_q) << oct_q;
  assign sy     = SX_W'(cy_q) << oct_q;
  assign cell_x = sx[FRACTION_BITS +: 32];
  assign cell_y = sy[FRACTION_BITS +: 32];

  if (FRACTION_BITS >= COS_TABLE_BITS) begin : g_idx_top
    assign idx_x = sx[FRACTION_BITS-1 -: COS_TABLE_BITS];
    assign idx_y = sy[FRACTION_BITS-1 -: COS_TABLE_BITS];
  end else begin : g_idx_pad
    assign idx_x = {sx[FRACTION_BITS-1:0], (COS_TABLE_BITS-FRACTION_BITS)'(0)};
    assign idx_y = {sy[FRACTION_BITS-1:0], (COS_TABLE_BITS-FRACTION_BITS)'(0)};
  end

  vn2o_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (state_q == S_ISSUE),
    .x_i     (cell_x + 32'(cnt_q[1:0]) - 32'd1),
    .y_i     (cell_y + 32'(cnt_q[3:2]) - 32'd1),
    .tag_i   (cnt_q),
    .valid_o (h_valid),
    .tag_o   (h_tag),
    .value_o (h_value)
  );

  // 3x3 weighted sums around each of the four cell corners
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sm_sum[c] = '0;
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          if (i == 1 && j == 1)
            sm_sum[c] = sm_sum[c] + (SM_W'(grid_q[((c>>1)+j)*4 + ((c&1)+i)]) <<< 2);
          else if (i == 1 || j == 1)
            sm_sum[c] = sm_sum[c] + (SM_W'(grid_q[((c>>1)+j)*4 + ((c&1)+i)]) <<< 1);
          else
            sm_sum[c] = sm_sum[c] + SM_W'(grid_q[((c>>1)+j)*4 + ((c&1)+i)]);
        end
      end
    end
  end

  always_comb begin
    case (cnt_q[1:0])
      2'd0: begin la = sm_q[0]; lb = sm_q[1]; lf = fx_q; end
      2'd1: begin la = sm_q[2]; lb = sm_q[3]; lf = fx_q; end
      default: begin la = bx0_q; lb = bx1_q; lf = fy_q; end
    endcase
  end

  assign ld   = (SM_W+1)'(lb) - (SM_W+1)'(la);
  assign lp   = ld * $signed({1'b0, lf});
  assign ls   = ((SM_W+20)'(la) <<< 16) + (SM_W+20)'(lp) + (SM_W+20)'(32768);
  assign lres = ls[16 +: SM_W];

  assign oa_prod  = o_q * $signed({1'b0, amp_q});
  assign amp_prod = amp_q * pers_q;
  assign amp_rnd  = amp_prod + (2*PERS_W)'(32768);

  assign acc_rnd  = acc_q + ACC_W'(64'sd8388608);
  assign res_wide = acc_rnd[ACC_W-1:24];
  always_comb begin
    if (res_wide > (ACC_W-24)'(64'sd2147483647)) res_sat = 32'sh7FFF_FFFF;
    else if (res_wide < -(ACC_W-24)'(64'sd2147483648)) res_sat = 32'sh8000_0000;
    else res_sat = res_wide[OUT_W-1:0];
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (q_valid_i) state_d = (q_item_i.octs == '0) ? S_FINAL : S_ISSUE;
      S_ISSUE:  if (cnt_q == 4'd15) state_d = S_WAIT;
      S_WAIT:   if (h_valid && h_tag == 4'd15) state_d = S_SMOOTH;
      S_SMOOTH: if (cnt_q == 4'd3) state_d = S_BLEND;
      S_BLEND:  if (cnt_q == 4'd2) state_d = S_ACC;
      S_ACC:    state_d = (oct_q + 4'd1 == octs_q) ? S_FINAL : S_ISSUE;
      S_FINAL:  if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 4'd0;
      oct_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) cnt_q <= 4'd0;
      else cnt_q <= cnt_q + 4'd1;
      if (state_q == S_IDLE) oct_q <= '0;
      else if (state_q == S_ACC) oct_q <= oct_q + 4'd1;
      if (state_q == S_FINAL && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cx_q   <= q_item_i.cx;
        cy_q   <= q_item_i.cy;
        octs_q <= q_item_i.octs;
        pers_q <= q_item_i.pers;
        amp_q  <= PERS_ONE;
        acc_q  <= '0;
      end
      S_ISSUE: begin
        fx_q <= cos_lut[idx_x];
        fy_q <= cos_lut[idx_y];
      end
      S_SMOOTH: sm_q[cnt_q[1:0]] <= sm_sum[cnt_q[1:0]];
      S_BLEND: begin
        if (cnt_q[1:0] == 2'd0) bx0_q <= lres;
        else if (cnt_q[1:0] == 2'd1) bx1_q <= lres;
        else o_q <= lres;
      end
      S_ACC: begin
        acc_q <= acc_q + ACC_W'(oa_prod);
        amp_q <= amp_rnd[16 +: PERS_W];
      end
      S_FINAL: if (out_free) res_q <= res_sat;
      default: ;
    endcase
    if (h_valid) grid_q[h_tag] <= h_value;
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = res_q;

  a_hash_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_valid |-> (state_q == S_ISSUE || state_q == S_WAIT))
    else $error("hash result outside its window");

  a_octave_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ACC |-> oct_q < octs_q) else $error("octave counter overrun");

endmodule

`default_nettype wire

### rtl/value_noise_2d_octaves.sv
// top level of the fractal 2d value noise block: front queue and octave back end
// depends on vn2o_pkg, vn2o_front, vn2o_back
`default_nettype none

// One request carries an unsigned Q15.16 point (coord_x_i, coord_y_i) and gives one signed
// Q5.26 noise_value_o, the sum of octave_count octaves of smoothed, cosine-blended lattice
// noise with amplitude ratio persistence. Each octave feeds the sixteen lattice corners of
// the 4x4 neighbourhood through the four-stage hash pipeline, drains it, smooths the four
// cell corners with 3x3 weighted sums, blends through one shared multiplier and accumulates;
// an item repeats these steps for each octave through the single hash pipeline. A two-entry
// queue takes new requests while the back end works, and a finished result waits in its
// output register while the next item is computed. The user must write configuration (index 0
// octave_count, index 1 persistence) only while idle; the block does not enforce this.

module value_noise_2d_octaves #(
  parameter int MAX_OCTAVES    = 8,
  parameter int FRACTION_BITS  = 16,
  parameter int COS_TABLE_BITS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [vn2o_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [vn2o_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [vn2o_pkg::COORD_W-1:0]   coord_x_i,
  input  wire logic [vn2o_pkg::COORD_W-1:0]   coord_y_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [vn2o_pkg::OUT_W-1:0]   noise_value_o
);
  import vn2o_pkg::*;

  // queue between the front and the back end
  vn2o_item_t q_item;
  logic       q_valid;
  logic       q_pop;

  vn2o_front #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .coord_x_i  (coord_x_i),
    .coord_y_i  (coord_y_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  // octave sequencer and arithmetic
  vn2o_back #(
    .FRACTION_BITS  (FRACTION_BITS),
    .COS_TABLE_BITS (COS_TABLE_BITS),
    .MAX_OCTAVES    (MAX_OCTAVES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .noise_value_o (noise_value_o)
  );

endmodule

`default_nettype wire
